FILE: src/broadcast_sum_reduce_top_assert.svh
// Assertion macros used by the broadcast sum reduce controller (bsr_ctrl).
`ifndef BROADCAST_SUM_REDUCE_TOP_ASSERT_SVH
`define BROADCAST_SUM_REDUCE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("broadcast_sum_reduce: same-cycle check failed");
`define BSR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("broadcast_sum_reduce: next-cycle check failed");
`else
`define BSR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BSR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: src/bsr_pkg.sv
`default_nettype none
package bsr_pkg;

    localparam int unsigned DIM_REGS  = 4;
    localparam int unsigned SIZE_W    = 9;
    localparam int unsigned MASK_W    = 4;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 9'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK = 3'd4;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ACC   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_SHAPE = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] grad_value;
        logic [7:0]         read_index;
    } bsr_in_t;

    typedef struct packed {
        logic signed [47:0] sum_value;
        logic [7:0]         out_index;
        logic               walk_done;
        logic [1:0]         status;
    } bsr_out_t;

    typedef struct packed {
        logic capture;
        logic idx_step;
        logic ram_rd;
        logic commit;
        logic clr_step;
    } bsr_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_last;
        logic       clr_last;
        logic       out_free;
    } bsr_sts_t;

endpackage
`default_nettype wire

FILE: src/bsr_ram.sv
`default_nettype none
module bsr_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: src/bsr_datapath.sv
`default_nettype none
module bsr_datapath
    import bsr_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = 256,
    parameter int unsigned RANK      = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [SIZE_W-1:0]    cfg_wr_data,
    input  wire bsr_in_t              s_data,
    input  wire bsr_cmd_t             cmd_i,
    output bsr_sts_t                  sts_o,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bsr_out_t                  m_data
);

    localparam int unsigned AW = $clog2(OUT_DEPTH);
    localparam int unsigned SW = $clog2(OUT_DEPTH + 1);
    localparam int unsigned IW = SW + 11;
    localparam int unsigned PW = SW + SIZE_W;
    localparam int unsigned DW = (RANK > 1) ? $clog2(RANK) : 1;
    localparam int unsigned RW = (AW > 8) ? AW + 1 : 9;

    localparam logic [IW-1:0] DEPTH_I   = IW'(OUT_DEPTH);
    localparam logic [RW-1:0] DEPTH_R   = RW'(OUT_DEPTH);
    localparam logic [PW-1:0] DEPTH_P   = PW'(OUT_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(OUT_DEPTH - 1);
    localparam logic [DW-1:0] LAST_STEP = DW'(RANK - 1);

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > SIZE_MAX) begin
            r = SIZE_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [SIZE_W-1:0]  size_reg [DIM_REGS];
    logic [MASK_W-1:0]  mask_reg;
    logic [7:0]         cnt_reg [RANK];
    logic [7:0]         cnt_next [RANK];
    logic [1:0]         op_reg;
    logic signed [31:0] grad_reg;
    logic [7:0]         ridx_reg;
    logic [IW-1:0]      idx_reg;
    logic [SW-1:0]      stride_reg;
    logic               ovf_reg;
    logic [DW-1:0]      step_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic               m_valid_reg;
    bsr_out_t           out_reg;

    logic [SIZE_W-1:0]  es [RANK];
    logic [RANK-1:0]    red;
    logic [7:0]         cnt_sel;
    logic [SIZE_W-1:0]  ks_sel;
    logic [SW+7:0]      term;
    logic [PW-1:0]      stride_prod;
    logic               carry;
    logic               walk_wrap;
    logic [47:0]        rdata;
    logic signed [48:0] sum_wide;
    logic               sum_ovf;
    logic signed [47:0] sat_sum;
    logic               shape_bad;
    logic [RW-1:0]      ridx_ext;
    logic               rd_bad;
    bsr_out_t           res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [47:0]        ram_wdata;
    logic [AW-1:0]      ram_raddr;

    for (genvar d = 0; d < RANK; d++) begin : g_dim
        if (d < DIM_REGS) begin : g_cfg
            assign es[d]  = clamp_size(size_reg[d]);
            assign red[d] = mask_reg[d];
        end else begin : g_fixed
            assign es[d]  = SIZE_W'(1);
            assign red[d] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIM_REGS; i++) begin
                size_reg[i] <= SIZE_W'(1);
            end
            mask_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_DIM0: size_reg[0] <= cfg_wr_data;
                CFG_DIM1: size_reg[1] <= cfg_wr_data;
                CFG_DIM2: size_reg[2] <= cfg_wr_data;
                CFG_DIM3: size_reg[3] <= cfg_wr_data;
                CFG_MASK: mask_reg    <= cfg_wr_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // kept-index step: one dimension per cycle, innermost first
    assign cnt_sel     = cnt_reg[step_reg];
    assign ks_sel      = red[step_reg] ? SIZE_W'(1) : es[step_reg];
    assign term        = red[step_reg] ? '0 : cnt_sel * stride_reg;
    assign stride_prod = stride_reg * ks_sel;

    always_comb begin
        carry = 1'b1;
        for (int d = RANK - 1; d >= 0; d--) begin
            cnt_next[d] = cnt_reg[d];
            if (carry) begin
                if (({1'b0, cnt_reg[d]} + SIZE_W'(1)) < es[d]) begin
                    cnt_next[d] = cnt_reg[d] + 8'd1;
                    carry       = 1'b0;
                end else begin
                    cnt_next[d] = '0;
                end
            end
        end
        walk_wrap = carry;
    end

    assign sum_wide  = $signed({rdata[47], rdata}) + 49'(grad_reg);
    assign sum_ovf   = sum_wide[48] != sum_wide[47];
    assign sat_sum   = sum_ovf ? (sum_wide[48] ? SUM_MIN : SUM_MAX) : sum_wide[47:0];
    assign shape_bad = ovf_reg || (idx_reg >= DEPTH_I);
    assign ridx_ext  = RW'(ridx_reg);
    assign rd_bad    = ridx_ext >= DEPTH_R;

    always_comb begin
        res = '0;
        case (op_reg)
            OP_ACC: begin
                res.walk_done = walk_wrap;
                if (shape_bad) begin
                    res.status = STAT_SHAPE;
                end else begin
                    res.sum_value = sat_sum;
                    res.out_index = idx_reg[7:0];
                    res.status    = sum_ovf ? STAT_SAT : STAT_OK;
                end
            end
            OP_READ: begin
                res.out_index = ridx_reg;
                if (rd_bad) begin
                    res.status = STAT_SHAPE;
                end else begin
                    res.sum_value = rdata;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            op_reg   <= s_data.operation;
            grad_reg <= s_data.grad_value;
            ridx_reg <= s_data.read_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.capture) begin
            idx_reg    <= '0;
            stride_reg <= SW'(1);
            ovf_reg    <= 1'b0;
            step_reg   <= LAST_STEP;
        end else if (cmd_i.idx_step) begin
            idx_reg  <= idx_reg + IW'(term);
            step_reg <= step_reg - DW'(1);
            if (!ovf_reg) begin
                if (stride_prod > DEPTH_P) begin
                    ovf_reg <= 1'b1;
                end else begin
                    stride_reg <= stride_prod[SW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < RANK; d++) begin
                cnt_reg[d] <= '0;
            end
        end else if (cmd_i.commit && (op_reg == OP_CLEAR)) begin
            for (int d = 0; d < RANK; d++) begin
                cnt_reg[d] <= '0;
            end
        end else if (cmd_i.commit && (op_reg == OP_ACC)) begin
            for (int d = 0; d < RANK; d++) begin
                cnt_reg[d] <= cnt_next[d];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd_i.clr_step) begin
            clr_addr_reg <= (clr_addr_reg == LAST_ADDR) ? '0 : clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.commit) begin
            out_reg <= res;
        end
    end

    assign ram_we    = cmd_i.clr_step || (cmd_i.commit && (op_reg == OP_ACC) && !shape_bad);
    assign ram_waddr = cmd_i.clr_step ? clr_addr_reg : idx_reg[AW-1:0];
    assign ram_wdata = cmd_i.clr_step ? '0 : sat_sum;
    assign ram_raddr = (op_reg == OP_READ) ? ridx_ext[AW-1:0] : idx_reg[AW-1:0];

    bsr_ram #(
        .WIDTH(48),
        .DEPTH(OUT_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd_i.ram_rd),
        .raddr(ram_raddr),
        .rdata(rdata)
    );

    assign sts_o.op       = op_reg;
    assign sts_o.idx_last = step_reg == '0;
    assign sts_o.clr_last = clr_addr_reg == LAST_ADDR;
    assign sts_o.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule
`default_nettype wire

FILE: src/bsr_ctrl.sv
`default_nettype none
`include "broadcast_sum_reduce_top_assert.svh"
module bsr_ctrl
    import bsr_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic [1:0] s_op,
    output logic            s_ready,
    output bsr_cmd_t        cmd_o,
    input  wire bsr_sts_t   sts_i
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_INDEX  = 5'b00100,
        S_READ   = 5'b01000,
        S_FINISH = 5'b10000
    } bsr_state_t;

    bsr_state_t state_reg;
    bsr_state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd_o.clr_step = 1'b1;
                if (sts_i.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd_o.capture = 1'b1;
                    case (s_op)
                        OP_ACC:  state_next = S_INDEX;
                        OP_READ: state_next = S_READ;
                        default: state_next = S_FINISH;
                    endcase
                end
            end
            S_INDEX: begin
                cmd_o.idx_step = 1'b1;
                if (sts_i.idx_last) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd_o.ram_rd = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH: begin
                if (sts_i.out_free) begin
                    cmd_o.commit = 1'b1;
                    state_next   = (sts_i.op == OP_CLEAR) ? S_CLEAR : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    `BSR_ASSERT_IMP(a_commit_slot_free, aclk, aresetn, cmd_o.commit, sts_i.out_free)
    `BSR_ASSERT_NXT(a_acc_starts_index, aclk, aresetn, s_valid && s_ready && (s_op == OP_ACC), cmd_o.idx_step)
    `BSR_ASSERT_IMP(a_no_accept_in_clear, aclk, aresetn, cmd_o.clr_step, !s_ready)
    `BSR_ASSERT_NXT(a_read_then_finish, aclk, aresetn, cmd_o.ram_rd, state_reg == S_FINISH)

endmodule
`default_nettype wire

FILE: src/broadcast_sum_reduce_top.sv
`default_nettype none
// Sums a row-major stream of gradient elements down to a broadcast source shape.
// Input channel (s_valid/s_ready/s_data): one transaction per operation: clear,
// accumulate (grad_value) or read (read_index). Result channel (m_valid/m_ready/
// m_data): exactly one transaction per input transaction, in order.
// Configuration: cfg_wr_en writes cfg_wr_data to dimension size or mask register
// cfg_wr_index; write only while no transaction is in flight. An accumulate
// steps through the dimensions one per cycle through the shared index
// multiply-add, then reads the accumulator RAM and writes the sum back; a read
// reads the RAM, and clear and unknown codes go straight to the result.
// s_ready rises together with the result valid. A clear also sweeps the
// accumulator RAM one entry per cycle before the next transaction is accepted.
// Reset sets the dimension sizes to 1 and clears the mask, the walk position
// and the result slot, then runs the same sweep.
// The result sits in an output register; a stalled receiver holds it there and
// the next transaction is still accepted, finishing when the slot frees.
module broadcast_sum_reduce_top
    import bsr_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = 256,
    parameter int unsigned RANK      = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  wire logic [SIZE_W-1:0]    cfg_wr_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bsr_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bsr_out_t                  m_data
);

    bsr_cmd_t cmd;
    bsr_sts_t sts;

    bsr_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_op   (s_data.operation),
        .s_ready(s_ready),
        .cmd_o  (cmd),
        .sts_i  (sts)
    );

    bsr_datapath #(
        .OUT_DEPTH(OUT_DEPTH),
        .RANK     (RANK)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_data      (s_data),
        .cmd_i       (cmd),
        .sts_o       (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
`default_nettype wire
